FILE: rtl/vlpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared types and constants of the LEB128 length-prefix deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

    localparam int          MAX_HEADER_BYTES_DEF = 10;
    localparam int          LENGTH_BITS_DEF      = 16;
    localparam int          CFG_BITS             = 16;
    localparam int          CHUNK_BITS           = 7;
    localparam int          COUNT_BITS           = 4;
    localparam int          SHIFT_BITS           = 7;
    localparam logic [15:0] MAX_FRAME_LENGTH_RST = 16'd1024;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_OVERLONG,
        ERR_OVERSIZE,
        ERR_TRUNCATED
    } t_err;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] payload;
        logic       last;
        t_err       err;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/vlpd_frame_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_frame_fsm
// Frame state and per-byte decode: header accumulation, payload count,
// error detection and discard until the end of the buffer.
// ----------------------------------------------------------------------------
module vlpd_frame_fsm #(
    parameter int MAX_HEADER_BYTES = vlpd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int LENGTH_BITS      = vlpd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_buffer_end,
    input  wire logic [vlpd_pkg::CFG_BITS-1:0]  i_max_len,
    output vlpd_pkg::t_result                   o_res
);
    import vlpd_pkg::*;

    localparam int WIDE_BITS = LENGTH_BITS + CHUNK_BITS;
    localparam int CMP_BITS  = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;

    t_phase                  r_phase, n_phase;
    logic [LENGTH_BITS-1:0]  r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    logic [COUNT_BITS-1:0]   r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0]  r_rem, n_rem;

    logic [CHUNK_BITS-1:0]   chunk;
    logic [SHIFT_BITS-1:0]   shift;
    logic                    shift_out;
    logic [WIDE_BITS-1:0]    placed;
    logic [LENGTH_BITS-1:0]  acc_upd;
    logic                    ovf_upd;
    logic [COUNT_BITS-1:0]   cnt_upd;
    logic                    more;
    logic                    too_long;
    logic                    too_big;
    logic                    len_zero;
    logic [LENGTH_BITS-1:0]  rem_dec;

    assign chunk     = i_data_byte[CHUNK_BITS-1:0];
    assign more      = i_data_byte[7];
    assign shift     = {r_cnt, 3'b000} - SHIFT_BITS'(r_cnt);
    assign shift_out = (shift >= SHIFT_BITS'(LENGTH_BITS));
    assign placed    = WIDE_BITS'(chunk) << shift;
    assign acc_upd   = shift_out ? r_acc : (r_acc | placed[LENGTH_BITS-1:0]);
    assign ovf_upd   = r_ovf | (shift_out ? (chunk != '0)
                                          : (placed[WIDE_BITS-1:LENGTH_BITS] != '0));
    assign cnt_upd   = r_cnt + COUNT_BITS'(1);
    assign too_long  = (cnt_upd >= COUNT_BITS'(MAX_HEADER_BYTES));
    assign too_big   = ovf_upd || (CMP_BITS'(acc_upd) > CMP_BITS'(i_max_len));
    assign len_zero  = (acc_upd == '0);
    assign rem_dec   = r_rem - LENGTH_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_acc = acc_upd;
                    n_ovf = ovf_upd;
                    n_cnt = cnt_upd;
                    if ((more && (too_long || i_buffer_end)) ||
                        (!more && (too_big || len_zero || i_buffer_end))) begin
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_cnt   = '0;
                        n_rem   = '0;
                        n_phase = PH_HEADER;
                        if (i_buffer_end == 1'b0 &&
                            ((more && too_long) || (!more && too_big))) begin
                            n_phase = PH_DISCARD;
                        end
                    end else if (!more) begin
                        n_rem   = acc_upd;
                        n_cnt   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0 || i_buffer_end) begin
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_cnt   = '0;
                        n_rem   = '0;
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    if (i_buffer_end) begin
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_cnt   = '0;
                        n_rem   = '0;
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res         = '0;
        o_res.kind    = KIND_PAYLOAD;
        o_res.err     = ERR_NONE;
        o_res.payload = '0;
        unique case (r_phase)
            PH_HEADER: begin
                if (more) begin
                    if (too_long) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_OVERLONG;
                    end else if (i_buffer_end) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_TRUNCATED;
                    end
                end else if (too_big) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.err   = ERR_OVERSIZE;
                end else if (len_zero) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_EMPTY;
                    o_res.last  = 1'b1;
                end else if (i_buffer_end) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.err   = ERR_TRUNCATED;
                end
            end
            PH_PAYLOAD: begin
                o_res.valid   = 1'b1;
                o_res.payload = i_data_byte;
                if (rem_dec == '0) begin
                    o_res.last = 1'b1;
                end else if (i_buffer_end) begin
                    o_res.err = ERR_TRUNCATED;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

`ifndef ASSERT_OFF
    a_payload_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != '0)
        else $error("Payload phase entered with zero bytes remaining.");

    a_header_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_cnt < COUNT_BITS'(MAX_HEADER_BYTES))
        else $error("Header byte count passed the header limit.");

    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DISCARD |-> (r_acc == '0 && r_rem == '0 && r_cnt == '0))
        else $error("Frame state not cleared while discarding.");

    a_header_error_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.err == ERR_OVERLONG || o_res.err == ERR_OVERSIZE))
        |-> (o_res.kind == KIND_ERROR && !o_res.last))
        else $error("Header error reported with a data result.");
`endif

endmodule
`default_nettype wire

FILE: rtl/varint_length_prefix_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer
// Splits a byte stream of LEB128 length-prefixed frames into payload bytes.
// ----------------------------------------------------------------------------
// Input bytes arrive on the s_axis channel, one per transaction; s_axis_tlast
// marks the last byte currently in the buffer. Results leave on m_axis:
// tdata is the payload byte, tlast marks the end of a frame and tuser holds
// the result kind and the error code. Header bytes give no result except on
// an error or an empty frame; bytes dropped after an error give none.
// The largest accepted payload length is written on the cfg channel, which
// is always ready; write it only while no transaction is in flight.
// Each byte is decoded in the cycle it is accepted and its result appears
// on m_axis in the next cycle. One byte is accepted every cycle as long as
// the output register is empty or being drained in the same cycle.
// When the receiver stalls, one result is held and s_axis_tready drops
// until it is taken. Reset is synchronous and active low; it returns the
// block to the header state, empties the output register and sets the
// length limit to 1024.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer #(
    parameter int MAX_HEADER_BYTES = vlpd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int LENGTH_BITS      = vlpd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // data_byte
    input  wire logic                          s_axis_tlast,  // buffer_end
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [7:0]                    m_axis_tdata,  // payload_byte
    output      logic                          m_axis_tlast,  // frame_last
    output      logic [3:0]                    m_axis_tuser,  // kind[1:0], error_code[3:2]
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [vlpd_pkg::CFG_BITS-1:0] i_cfg_data
);
    import vlpd_pkg::*;

    logic [CFG_BITS-1:0] r_max;
    logic                accept;
    t_result             res;
    logic                r_valid;
    logic [7:0]          r_payload;
    logic                r_last;
    t_kind               r_kind;
    t_err                r_err;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FRAME_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max <= i_cfg_data;
        end
    end

    vlpd_frame_fsm #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (s_axis_tdata),
        .i_buffer_end (s_axis_tlast),
        .i_max_len    (r_max),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= res.valid;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res.valid) begin
            r_payload <= res.payload;
            r_last    <= res.last;
            r_kind    <= res.kind;
            r_err     <= res.err;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_payload;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = {r_err, r_kind};

endmodule
`default_nettype wire

FILE: verif/varint_length_prefix_deframer_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer_checker
// Decodes the accepted byte stream alongside the deframer and compares results.
// ----------------------------------------------------------------------------
// Every accepted input transaction runs through a LEB128 frame decoder kept
// here. The decoder tracks the length register, the header state and the
// payload count, and queues the result that the byte should produce. Every
// accepted output transaction is compared field by field with the oldest
// queued result. The mismatch count and the number of results still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [7:0]                    i_in_data,
    input  wire logic                          i_in_end,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [7:0]                    i_out_data,
    input  wire logic                          i_out_last,
    input  wire logic [3:0]                    i_out_user,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [vlpd_pkg::CFG_BITS-1:0] i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import vlpd_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       last;
        t_err       err;
    } t_deframe_result;

    t_deframe_result expected_results[$];
    t_deframe_result want;
    int              mismatch_count = 0;

    logic [15:0] max_len   = MAX_FRAME_LENGTH_RST;
    t_phase      phase     = PH_HEADER;
    logic [15:0] len_acc   = '0;
    logic        len_ovf   = 1'b0;
    logic [3:0]  hdr_count = '0;
    logic [15:0] remaining = '0;

    task automatic clear_frame();
        phase     = PH_HEADER;
        len_acc   = '0;
        len_ovf   = 1'b0;
        hdr_count = '0;
        remaining = '0;
    endtask

    task automatic push_result(input t_kind kind, input logic [7:0] payload,
                               input logic last, input t_err err);
        t_deframe_result res;
        res.kind    = kind;
        res.payload = payload;
        res.last    = last;
        res.err     = err;
        expected_results.push_back(res);
    endtask

    task automatic frame_error(input t_err err, input logic eob);
        clear_frame();
        if (!eob) begin
            phase = PH_DISCARD;
        end
        push_result(KIND_ERROR, 8'h00, 1'b0, err);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        logic [6:0]  chunk;
        logic [31:0] widened;
        int          shift;
        if (phase == PH_HEADER) begin
            chunk = b[6:0];
            shift = 7 * int'(hdr_count);
            if (shift >= LENGTH_BITS_DEF) begin
                if (chunk != 0) begin
                    len_ovf = 1'b1;
                end
            end else begin
                widened = {25'd0, chunk} << shift;
                if (widened[31:16] != 0) begin
                    len_ovf = 1'b1;
                end
                len_acc = len_acc | widened[15:0];
            end
            hdr_count = hdr_count + 4'd1;
            if (b[7]) begin
                if (hdr_count >= MAX_HEADER_BYTES_DEF) begin
                    frame_error(ERR_OVERLONG, eob);
                end else if (eob) begin
                    frame_error(ERR_TRUNCATED, 1'b1);
                end
            end else if (len_ovf || len_acc > max_len) begin
                frame_error(ERR_OVERSIZE, eob);
            end else if (len_acc == 0) begin
                clear_frame();
                push_result(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
            end else if (eob) begin
                frame_error(ERR_TRUNCATED, 1'b1);
            end else begin
                remaining = len_acc;
                phase     = PH_PAYLOAD;
                hdr_count = '0;
            end
        end else if (phase == PH_PAYLOAD) begin
            remaining = remaining - 16'd1;
            if (remaining == 0) begin
                clear_frame();
                push_result(KIND_PAYLOAD, b, 1'b1, ERR_NONE);
            end else if (eob) begin
                clear_frame();
                push_result(KIND_PAYLOAD, b, 1'b0, ERR_TRUNCATED);
            end else begin
                push_result(KIND_PAYLOAD, b, 1'b0, ERR_NONE);
            end
        end else if (eob) begin
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len = MAX_FRAME_LENGTH_RST;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: kind=%0d byte=%02h last=%0b err=%0d",
                                 i_out_user[1:0], i_out_data, i_out_last, i_out_user[3:2]);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_user[1:0] !== want.kind || i_out_data !== want.payload ||
                        i_out_last !== want.last || i_out_user[3:2] !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected kind=%0d byte=%02h last=%0b err=%0d",
                                     want.kind, want.payload, want.last, want.err);
                            $display("          got      kind=%0d byte=%02h last=%0b err=%0d",
                                     i_out_user[1:0], i_out_data, i_out_last,
                                     i_out_user[3:2]);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data, i_in_end);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_data;
            end
        end
        o_outstanding <= expected_results.size();
        o_mismatches  <= mismatch_count;
    end

endmodule
`default_nettype wire

FILE: verif/varint_length_prefix_deframer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer_tb
// Stream test of the LEB128 length-prefix deframer.
// ----------------------------------------------------------------------------
// A short directed sequence covers empty frames, boundary lengths, length
// overflow, overlong headers and both kinds of truncation. Random frames
// follow under several length limits, mostly well formed with random
// content, the rest truncated or oversize frames, broken headers and noise.
// The sender works in bursts and the receiver stalls on its own pattern,
// with two long hold-offs that back the block up. The checker does the prediction.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [15:0] i_cfg_data    = 16'h0000;
    wire logic       s_axis_tready;
    wire logic       m_axis_tvalid;
    wire logic [7:0] m_axis_tdata;
    wire logic       m_axis_tlast;
    wire logic [3:0] m_axis_tuser;
    wire logic       o_cfg_ready;
    int              mismatches;
    int              outstanding;

    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          bytes_sent    = 0;
    int          ignored_bytes = 0;
    logic [15:0] frame_limit   = vlpd_pkg::MAX_FRAME_LENGTH_RST;
    logic [15:0] limit_plan [6];

    int rx_cycle  = 0;
    int hold_left = 0;
    int mode_left = 0;
    int rx_mode   = 0;

    varint_length_prefix_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    varint_length_prefix_deframer_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_end      (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .i_out_user    (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver switches between stall patterns and twice holds off long
    // enough for the output register to fill and the input to back up.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle == 1500 || rx_cycle == 5000) begin
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_axis_tready <= ((rx_cycle % 5) == 0);
                end
            endcase
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic offer_byte(input logic [7:0] data, input logic eob);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= eob;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        frame_limit = value;
    endtask

    // Sends a LEB128 length, padded with redundant zero groups when pad is
    // nonzero. The end-of-buffer flag goes on the final header byte.
    task automatic send_length(input int len, input int pad, input logic eob);
        int   rest;
        logic more;
        rest = len;
        do begin
            more = (rest > 127) || (pad > 0);
            offer_byte({more, 7'(rest)}, !more && eob);
            rest = rest >> 7;
        end while (rest != 0);
        for (int i = 0; i < pad; i++) begin
            offer_byte({i != pad - 1, 7'h00}, (i == pad - 1) && eob);
        end
    endtask

    task automatic drop_until_end();
        int n;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            offer_byte(8'($urandom), 1'b0);
        end
        offer_byte(8'($urandom), 1'b1);
        ignored_bytes += n + 1;
    endtask

    task automatic random_frames(input int target);
        int   start;
        int   pick;
        int   len;
        int   cap;
        int   pad;
        int   n;
        logic eob;
        start = bytes_sent - ignored_bytes;
        while (bytes_sent - ignored_bytes - start < target) begin
            pick = $urandom_range(0, 99);
            pad  = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 7) : 0;
            eob  = $urandom_range(0, 1);
            if (pick < 55 || (pick < 67 && frame_limit < 2)) begin
                cap = ($urandom_range(0, 6) == 0) ? 200 : 12;
                cap = (frame_limit < cap) ? int'(frame_limit) : cap;
                len = $urandom_range(0, cap);
                eob = ($urandom_range(0, 3) == 0);
                send_length(len, pad, (len == 0) && eob);
                for (int i = 0; i < len; i++) begin
                    offer_byte(8'($urandom), (i == len - 1) && eob);
                end
            end else if (pick < 67) begin
                len = $urandom_range(2, frame_limit);
                send_length(len, pad, 1'b0);
                n = $urandom_range(1, (len - 1 < 16) ? len - 1 : 16);
                for (int i = 0; i < n; i++) begin
                    offer_byte(8'($urandom), i == n - 1);
                end
            end else if (pick < 75) begin
                if (eob || frame_limit == 0) begin
                    n = $urandom_range(1, 9);
                    for (int i = 0; i < n; i++) begin
                        offer_byte({1'b1, 7'($urandom)}, i == n - 1);
                    end
                end else begin
                    send_length($urandom_range(1, frame_limit), pad, 1'b1);
                end
            end else if (pick < 83) begin
                for (int i = 0; i < 10; i++) begin
                    offer_byte({1'b1, 7'($urandom)}, (i == 9) && eob);
                end
                if (!eob) begin
                    drop_until_end();
                end
            end else if (pick < 92) begin
                if (frame_limit < 16'hFFFF && $urandom_range(0, 1) == 1) begin
                    send_length($urandom_range(int'(frame_limit) + 1, 65535), 0, eob);
                end else if ($urandom_range(0, 1) == 1) begin
                    offer_byte({1'b1, 7'($urandom)}, 1'b0);
                    offer_byte({1'b1, 7'($urandom)}, 1'b0);
                    offer_byte({1'b0, 7'($urandom_range(4, 127))}, eob);
                end else begin
                    offer_byte({1'b1, 7'($urandom)}, 1'b0);
                    offer_byte({1'b1, 7'($urandom)}, 1'b0);
                    offer_byte({1'b1, 7'($urandom)}, 1'b0);
                    offer_byte({1'b0, 7'($urandom_range(1, 127))}, eob);
                end
                if (!eob) begin
                    drop_until_end();
                end
            end else begin
                // Noise, then a continuation byte that ends the buffer, which
                // returns the block to a clean header from any state.
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    offer_byte(8'($urandom), 1'($urandom));
                end
                offer_byte({1'b1, 7'($urandom)}, 1'b1);
            end
        end
    endtask

    initial begin
        limit_plan = '{16'hFFFF, 16'h0000, 16'($urandom_range(1, 16)),
                       16'($urandom_range(17, 65534)), 16'h0001, 16'd300};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_byte(8'h00, 1'b0);
        offer_byte(8'h01, 1'b0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h08, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h5A, 1'b1);
        offer_byte(8'h81, 1'b0);
        offer_byte(8'h08, 1'b0);
        offer_byte(8'h7F, 1'b1);
        offer_byte(8'h80, 1'b1);
        offer_byte(8'h05, 1'b1);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h04, 1'b1);
        for (int i = 0; i < 10; i++) begin
            offer_byte(8'hFF, i == 9);
        end
        wait_drained();

        foreach (limit_plan[p]) begin
            write_limit(limit_plan[p]);
            random_frames(180);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: varint_length_prefix_deframer.f
rtl/vlpd_pkg.sv
rtl/vlpd_frame_fsm.sv
rtl/varint_length_prefix_deframer.sv
verif/varint_length_prefix_deframer_checker.sv
verif/varint_length_prefix_deframer_tb.sv
